// ----- hw/rtl/set_associative_cache_lookup_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache lookup
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_CACHE_LOOKUP_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on a given clock, idle while the given reset is low
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on the block clock and reset
`define SACL_ASSERT_STD(lbl, prop, msg) \
  `SACL_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SACL_ASSERT_STD(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/sacl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup package
// Shared constants, codes, sequencer states and the LFSR step function.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Parameter defaults
  localparam int unsigned MAX_SET_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF     = 8;
  localparam int unsigned ADDR_BITS_DEF    = 32;
  localparam int unsigned AGE_BITS_DEF     = 16;

  // Fixed field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Random replacement generator
  localparam int unsigned       LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 8'd3;

  // Reset values of the registers
  localparam logic [2:0] SET_BITS_RST = 3'd0;
  localparam logic [3:0] WAYS_RST     = 4'd1;
  localparam logic [4:0] OFFSET_RST   = 5'd4;
  localparam logic [1:0] POLICY_RST   = 2'd0;

  // Replacement policy codes; any other code picks at random
  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_MRU  = 2'd1;
  localparam logic [1:0] POL_RAND = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FILL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EVICT = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_RESOLVE = 6'b001000,
    ST_MOD     = 6'b010000,
    ST_WRITE   = 6'b100000
  } state_e;

  // Galois LFSR, shifted right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/sacl_mod_unit.sv -----
`timescale 1ns / 1ps
`include "set_associative_cache_lookup_macros.svh"
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Reduces an LFSR word modulo a small divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sacl_mod_unit #(
  parameter int unsigned DIV_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sacl_pkg::LFSR_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]          divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [DIV_W-1:0]          rem_o
);
  import sacl_pkg::*;

  localparam int unsigned CNT_W = $clog2(LFSR_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LFSR_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [LFSR_W-1:0] dvd_q, dvd_d;
  logic [DIV_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[LFSR_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      // shift in the next bit, subtract once when it fits
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = DIV_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

  `SACL_ASSERT_STD(a_rem_below_div, done_q |-> rem_q < div_q, "remainder not below divisor")
  `SACL_ASSERT_STD(a_start_busy, start_i |=> busy_q, "unit not busy after start")
  `SACL_ASSERT_STD(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q,
                   "done without a finished run")

endmodule

// ----- hw/rtl/set_associative_cache_lookup.sv -----
`timescale 1ns / 1ps
`include "set_associative_cache_lookup_macros.svh"
// ----------------------------------------------------------------------------
// Set-associative cache lookup
// Tag lookup, fill and replacement for a simulated cache with LRU, MRU or
// random victim choice.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one byte address per word. m_axis returns one word per
//   address: tuser is the status (hit, fill of an empty way, eviction) and
//   tdata the evicted line address, zero unless a line was evicted.
//   The cfg channel writes the four registers (set bits, ways, offset bits,
//   policy); write it only while no lookup is in flight. cfg_ready_o is
//   always high.
//   Each lookup reads the whole set row in the accept cycle, walks the ways
//   one per cycle through a single age/tag compare unit, resolves, then
//   writes the row back and loads the output register. A random eviction
//   adds the LFSR step and the bit-serial remainder by the way count.
//   After reset a clearing pass zeroes the set memory one row per cycle
//   (all 2**MAX_SET_BITS rows, 64 by default) with s_axis_tready_o low.
//   A new address is taken while the last result still waits; a stalled
//   receiver holds the block in its write-back step until the output
//   register frees up.
// ----------------------------------------------------------------------------
module set_associative_cache_lookup #(
  parameter int unsigned MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS    = sacl_pkg::ADDR_BITS_DEF,
  parameter int unsigned AGE_BITS     = sacl_pkg::AGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // address stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sacl_pkg::ADDR_W-1:0]       s_axis_tdata_i,  // [31:0] address
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sacl_pkg::ADDR_W-1:0]       m_axis_tdata_o,  // [31:0] evicted_address
  output logic [sacl_pkg::STATUS_W-1:0]     m_axis_tuser_o,  // [1:0] status
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sacl_pkg::*;

  localparam int unsigned SETS   = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned LW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned E_W    = 1 + LW + AGE_BITS;
  localparam int unsigned ROW_W  = MAX_WAYS * E_W;
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

  // Registers
  logic [2:0] sbits_q;
  logic [3:0] ways_cfg_q;
  logic [4:0] off_q;
  logic [1:0] pol_q;

  // Sequencer and control
  state_e            state_q, state_d;
  logic [SET_W-1:0]  clr_q, clr_d;
  logic [WAY_W-1:0]  way_q, way_d;
  logic              hit_q, hit_d;
  logic              inv_q, inv_d;
  logic              out_valid_q, out_valid_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;

  // Item payload
  logic [ROW_W-1:0]    row_q, row_d, row_wr;
  logic [LW-1:0]       line_q, line_d;
  logic [SET_W-1:0]    set_q, set_d;
  logic [WAY_W-1:0]    hit_way_q, hit_way_d;
  logic [WAY_W-1:0]    inv_way_q, inv_way_d;
  logic [WAY_W-1:0]    best_way_q, best_way_d;
  logic [AGE_BITS-1:0] best_age_q, best_age_d;
  logic [WAY_W-1:0]    tgt_q, tgt_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic [STATUS_W-1:0] out_stat_q, out_stat_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;

  // Set row memory
  logic [ROW_W-1:0] mem [SETS];
  logic             mem_we;
  logic [SET_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wd;

  // Effective configuration
  logic [2:0]        sbits_eff;
  logic [WCNT_W-1:0] ways_eff;

  // Address split
  logic [LW-1:0]       addr_in;
  logic [LW-1:0]       line_in;
  logic [LW+SET_W-1:0] shifted_in;
  logic [SET_W-1:0]    set_in;

  // Way under scan
  logic [E_W-1:0]      ent;
  logic                ent_valid;
  logic [LW-1:0]       ent_addr;
  logic [AGE_BITS-1:0] ent_age;
  logic [AGE_BITS-1:0] aged;
  logic                last_way;
  logic                take_best;
  logic [LW-1:0]       victim_addr;

  // Remainder unit
  logic              mod_start;
  logic              mod_busy;
  logic              mod_done;
  logic [WCNT_W-1:0] mod_rem;

  logic in_fire;
  logic out_free;

  // Clamp out-of-range register values
  always_comb begin
    sbits_eff = (32'(sbits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : sbits_q;
    if (ways_cfg_q == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_cfg_q) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_cfg_q);
    end
  end

  // Drop the line offset for the line address; set bits above the
  // address read as zero
  assign addr_in    = s_axis_tdata_i[LW-1:0];
  assign line_in    = addr_in & ({LW{1'b1}} << off_q);
  assign shifted_in = {{SET_W{1'b0}}, addr_in} >> off_q;
  assign set_in     = shifted_in[SET_W-1:0] & ~({SET_W{1'b1}} << sbits_eff);

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Shared compare unit: one way per cycle
  always_comb begin
    ent       = row_q[32'(way_q) * E_W +: E_W];
    ent_valid = ent[E_W-1];
    ent_addr  = ent[AGE_BITS +: LW];
    ent_age   = ent[AGE_BITS-1:0];
    aged      = (ent_age == {AGE_BITS{1'b1}}) ? ent_age : ent_age + 1'b1;
    last_way  = (32'(way_q) + 1) == 32'(ways_eff);
    take_best = (way_q == '0) ||
                ((pol_q == POL_LRU) && (aged > best_age_q)) ||
                ((pol_q == POL_MRU) && (aged < best_age_q));
  end

  // Row as written back: the chosen way gets the new line, valid, age zero
  always_comb begin
    row_wr = row_q;
    row_wr[32'(tgt_q) * E_W +: E_W] = {1'b1, line_q, {AGE_BITS{1'b0}}};
    victim_addr = row_q[32'(tgt_q) * E_W + AGE_BITS +: LW];
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    way_d       = way_q;
    hit_d       = hit_q;
    inv_d       = inv_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    lfsr_d      = lfsr_q;
    row_d       = row_q;
    line_d      = line_q;
    set_d       = set_q;
    hit_way_d   = hit_way_q;
    inv_way_d   = inv_way_q;
    best_way_d  = best_way_q;
    best_age_d  = best_age_q;
    tgt_d       = tgt_q;
    stat_d      = stat_q;
    out_stat_d  = out_stat_q;
    out_addr_d  = out_addr_q;
    mem_we      = 1'b0;
    mem_wa      = set_q;
    mem_wd      = row_wr;
    mod_start   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        // zero one row per cycle
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == SET_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          line_d  = line_in;
          set_d   = set_in;
          way_d   = '0;
          hit_d   = 1'b0;
          inv_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // age the way, then look for a hit, a free way and the victim
        row_d[32'(way_q) * E_W +: E_W] = {ent_valid, ent_addr, aged};
        if (ent_valid && (ent_addr == line_q) && !hit_q) begin
          hit_d     = 1'b1;
          hit_way_d = way_q;
        end
        if (!ent_valid && !inv_q) begin
          inv_d     = 1'b1;
          inv_way_d = way_q;
        end
        if (take_best) begin
          best_way_d = way_q;
          best_age_d = aged;
        end
        way_d = way_q + 1'b1;
        if (last_way) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (hit_q) begin
          tgt_d   = hit_way_q;
          stat_d  = STAT_HIT;
          state_d = ST_WRITE;
        end else if (inv_q) begin
          tgt_d   = inv_way_q;
          stat_d  = STAT_FILL;
          state_d = ST_WRITE;
        end else if ((pol_q == POL_LRU) || (pol_q == POL_MRU)) begin
          tgt_d   = best_way_q;
          stat_d  = STAT_EVICT;
          state_d = ST_WRITE;
        end else begin
          // advance the LFSR and reduce it by the way count
          lfsr_d    = lfsr_next(lfsr_q);
          mod_start = 1'b1;
          stat_d    = STAT_EVICT;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          tgt_d   = WAY_W'(mod_rem);
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (out_free) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_addr_d  = (stat_q == STAT_EVICT) ? ADDR_W'(victim_addr) : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory write and registered row read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_fire) begin
      row_q <= mem[set_in];
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      lfsr_q      <= LFSR_SEED;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      way_q       <= way_d;
      hit_q       <= hit_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
      lfsr_q      <= lfsr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q     <= line_d;
    set_q      <= set_d;
    hit_way_q  <= hit_way_d;
    inv_way_q  <= inv_way_d;
    best_way_q <= best_way_d;
    best_age_q <= best_age_d;
    tgt_q      <= tgt_d;
    stat_q     <= stat_d;
    out_stat_q <= out_stat_d;
    out_addr_q <= out_addr_d;
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbits_q    <= SET_BITS_RST;
      ways_cfg_q <= WAYS_RST;
      off_q      <= OFFSET_RST;
      pol_q      <= POLICY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SET_BITS: sbits_q    <= cfg_data_i[2:0];
        REG_WAYS:     ways_cfg_q <= cfg_data_i[3:0];
        REG_OFFSET:   off_q      <= cfg_data_i[4:0];
        REG_POLICY:   pol_q      <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  sacl_mod_unit #(
    .DIV_W(WCNT_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(lfsr_d),
    .divisor_i (ways_eff),
    .busy_o    (mod_busy),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign cfg_ready_o     = 1'b1;

  `SACL_ASSERT_STD(a_scan_in_range, (state_q == ST_SCAN) |-> 32'(way_q) < 32'(ways_eff),
                   "scan past the ways in use")
  `SACL_ASSERT_STD(a_mod_running, (state_q == ST_MOD) |-> mod_busy || mod_done,
                   "waiting on an idle remainder unit")
  `SACL_ASSERT_STD(a_zero_unless_evict,
                   m_axis_tvalid_o && (m_axis_tuser_o != STAT_EVICT) |-> m_axis_tdata_o == '0,
                   "nonzero evicted address without eviction")
  `SACL_ASSERT_STD(a_accept_starts_scan, in_fire |=> (state_q == ST_SCAN) && (way_q == '0),
                   "accepted word did not start a scan")

endmodule
